/* design/gncp_pkg.sv */
// gncp_pkg: constants, types and helper functions for the grid neighbour
// count and peeling block
// depends on nothing
`default_nettype none

package gncp_pkg;

  // grid geometry limits
  localparam int MAX_ROWS = 256;
  localparam int MAX_COLS = 256;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROWS_W   = $clog2(MAX_ROWS + 1);
  localparam int COLS_W   = $clog2(MAX_COLS + 1);
  localparam int ADDR_W   = $clog2(MAX_ROWS * MAX_COLS);
  localparam int MAX_CELLS = MAX_ROWS * MAX_COLS;

  // field and register widths
  localparam int CFG_DIM_W  = 9;
  localparam int LIMIT_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int COUNT_W    = 17;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // register reset values
  localparam logic [CFG_DIM_W-1:0] GRID_ROWS_RESET       = CFG_DIM_W'(1);
  localparam logic [CFG_DIM_W-1:0] GRID_COLS_RESET       = CFG_DIM_W'(1);
  localparam logic [LIMIT_W-1:0]   NEIGHBOUR_LIMIT_RESET = LIMIT_W'(4);

  // per-cell sequencer steps: center read, eight neighbour reads, decision
  localparam int NB_W   = 4;
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_CENTER   = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_FIRST_NB = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_LAST_NB  = STEP_W'(8);
  localparam logic [STEP_W-1:0] STEP_DECIDE   = STEP_W'(9);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS       = 2'd0,
    REG_GRID_COLS       = 2'd1,
    REG_NEIGHBOUR_LIMIT = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    OFF_MINUS,
    OFF_ZERO,
    OFF_PLUS
  } offset_t;

  // row offset of the cell read at a given step
  function automatic offset_t step_dr(logic [STEP_W-1:0] k);
    offset_t o;
    unique case (k) inside
      4'd1, 4'd2, 4'd3: o = OFF_MINUS;
      4'd6, 4'd7, 4'd8: o = OFF_PLUS;
      default:          o = OFF_ZERO;
    endcase
    return o;
  endfunction

  // column offset of the cell read at a given step
  function automatic offset_t step_dc(logic [STEP_W-1:0] k);
    offset_t o;
    unique case (k) inside
      4'd1, 4'd4, 4'd6: o = OFF_MINUS;
      4'd3, 4'd5, 4'd8: o = OFF_PLUS;
      default:          o = OFF_ZERO;
    endcase
    return o;
  endfunction

  // zero acts as one, oversized acts as the maximum
  function automatic logic [ROWS_W-1:0] eff_rows(logic [CFG_DIM_W-1:0] v);
    logic [ROWS_W-1:0] n;
    if (v == '0) n = ROWS_W'(1);
    else if (int'(v) > MAX_ROWS) n = ROWS_W'(MAX_ROWS);
    else n = ROWS_W'(v);
    return n;
  endfunction

  function automatic logic [COLS_W-1:0] eff_cols(logic [CFG_DIM_W-1:0] v);
    logic [COLS_W-1:0] n;
    if (v == '0) n = COLS_W'(1);
    else if (int'(v) > MAX_COLS) n = COLS_W'(MAX_COLS);
    else n = COLS_W'(v);
    return n;
  endfunction

  // saturating count increment
  function automatic logic [COUNT_W-1:0] sat_inc(logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_W'(1);
  endfunction

endpackage

`default_nettype wire

/* design/gncp_if.sv */
// gncp_if: valid/ready channel interfaces for cells, results and configuration
// depends on gncp_pkg
`default_nettype none

// one grid cell per item
interface gncp_cell_if;
  import gncp_pkg::*;
  logic valid;
  logic ready;
  logic cell_occupied;
  modport source (output valid, output cell_occupied, input ready);
  modport sink (input valid, input cell_occupied, output ready);
endinterface

// one result item per loaded grid
interface gncp_result_if;
  import gncp_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] single_pass_count;
  logic [COUNT_W-1:0] total_removed;
  modport source (output valid, output single_pass_count, output total_removed,
                  input ready);
  modport sink (input valid, input single_pass_count, input total_removed,
                output ready);
endinterface

// register write channel
interface gncp_cfg_if;
  import gncp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/grid_neighbour_count_peeling.sv */
// grid_neighbour_count_peeling: loads a binary grid, counts low-neighbour cells
// and peels them until stable; one shared read/count unit under a sequencer
// depends on gncp_pkg and gncp_if
//
//   channel  dir  handshake     payload
//   cells    in   valid/ready   cell_occupied
//   results  out  valid/ready   single_pass_count, total_removed
//   cfg      in   valid/ready   index, data (ready always high)
//
// load: one cell per cycle while cells are valid, rows*cols cells for a grid
// scan: every cell is tested one read a cycle on the single cell-store port:
//   an empty cell ends after its center read, an occupied one takes center +
//   8 neighbours + decision; one counting pass, then peeling passes until one clears
//   nothing, so at least two full passes per grid, plus a finishing state
// reset: synchronous, active high; the cell store is not cleared, every cell
//   is written by the load before any read
// stalls: the result waits in an output register while the next grid loads;
//   the scan of that grid holds in its finishing state until the slot is free
`default_nettype none

module grid_neighbour_count_peeling import gncp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  gncp_cell_if.sink      cells,
  gncp_result_if.source  results,
  gncp_cfg_if.sink       cfg
);

  // cell store, one bit per cell, row-major with a fixed row pitch
  logic cell_store [MAX_CELLS];

  state_t state, state_next;

  logic [CFG_DIM_W-1:0] grid_rows;
  logic [CFG_DIM_W-1:0] grid_cols;
  logic [LIMIT_W-1:0]   neighbour_limit;

  logic [ROW_W-1:0]   r, r_next;
  logic [COL_W-1:0]   c, c_next;
  logic [STEP_W-1:0]  step, step_next;
  logic               peel, peel_next;
  logic [NB_W-1:0]    nb_count, nb_count_next;
  logic [COUNT_W-1:0] first_count, first_count_next;
  logic [COUNT_W-1:0] removed_count, removed_count_next;
  logic               pass_changed, pass_changed_next;
  logic               rd_ok, rd_ok_next;
  logic               rd_data;

  logic               out_valid;
  logic               out_load;
  logic [COUNT_W-1:0] out_single;
  logic [COUNT_W-1:0] out_total;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic              mem_wdata;

  logic [ROWS_W-1:0] rows_eff;
  logic [COLS_W-1:0] cols_eff;
  logic              last_row, last_col;
  logic [ADDR_W-1:0] center_addr, nb_addr;
  logic [ROW_W-1:0]  nr;
  logic [COL_W-1:0]  nc;
  logic              row_ok, col_ok;
  logic [NB_W-1:0]   nb_sum;
  logic              cell_done, removable, cleared, changed;
  logic              geom_write;
  offset_t           dr, dc;

  // geometry and position
  assign rows_eff    = eff_rows(grid_rows);
  assign cols_eff    = eff_cols(grid_cols);
  assign last_row    = (ROWS_W'(r) + ROWS_W'(1)) == rows_eff;
  assign last_col    = (COLS_W'(c) + COLS_W'(1)) == cols_eff;
  assign center_addr = ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);

  // neighbour coordinates and in-grid test for the current step
  assign dr = step_dr(step);
  assign dc = step_dc(step);

  always_comb begin
    unique case (dr)
      OFF_MINUS: begin
        row_ok = (r != '0);
        nr     = r - ROW_W'(1);
      end
      OFF_PLUS: begin
        row_ok = (ROWS_W'(r) + ROWS_W'(1)) < rows_eff;
        nr     = r + ROW_W'(1);
      end
      default: begin
        row_ok = 1'b1;
        nr     = r;
      end
    endcase
  end

  always_comb begin
    unique case (dc)
      OFF_MINUS: begin
        col_ok = (c != '0);
        nc     = c - COL_W'(1);
      end
      OFF_PLUS: begin
        col_ok = (COLS_W'(c) + COLS_W'(1)) < cols_eff;
        nc     = c + COL_W'(1);
      end
      default: begin
        col_ok = 1'b1;
        nc     = c;
      end
    endcase
  end

  assign nb_addr = ADDR_W'(nr) * ADDR_W'(MAX_COLS) + ADDR_W'(nc);

  // running neighbour count including the read that just returned
  assign nb_sum = nb_count + NB_W'(rd_ok & rd_data);

  assign geom_write = cfg.valid &&
                      ((cfg_reg_t'(cfg.index) == REG_GRID_ROWS) ||
                       (cfg_reg_t'(cfg.index) == REG_GRID_COLS));

  // sequencer: load, scan passes, finish
  always_comb begin
    state_next         = state;
    r_next             = r;
    c_next             = c;
    step_next          = step;
    peel_next          = peel;
    nb_count_next      = nb_count;
    first_count_next   = first_count;
    removed_count_next = removed_count;
    pass_changed_next  = pass_changed;
    rd_ok_next         = rd_ok;
    mem_we             = 1'b0;
    mem_waddr          = center_addr;
    mem_wdata          = 1'b0;
    out_load           = 1'b0;
    cell_done          = 1'b0;
    removable          = 1'b0;
    cleared            = 1'b0;
    changed            = pass_changed;

    unique case (state)
      ST_LOAD: begin
        if (cells.valid) begin
          mem_we    = 1'b1;
          mem_wdata = cells.cell_occupied;
          if (last_col) begin
            c_next = '0;
            if (last_row) begin
              r_next             = '0;
              state_next         = ST_SCAN;
              step_next          = STEP_CENTER;
              nb_count_next      = '0;
              peel_next          = 1'b0;
              first_count_next   = '0;
              removed_count_next = '0;
              pass_changed_next  = 1'b0;
            end else begin
              r_next = r + ROW_W'(1);
            end
          end else begin
            c_next = c + COL_W'(1);
          end
        end
      end

      ST_SCAN: begin
        // issue this step's read, remember whether it lies inside the grid
        if (step <= STEP_LAST_NB) begin
          rd_ok_next = row_ok & col_ok;
        end
        // an empty center ends the test early
        if (step == STEP_FIRST_NB) begin
          if (!rd_data) cell_done = 1'b1;
        end else if (step > STEP_FIRST_NB) begin
          nb_count_next = nb_sum;
        end
        if (step == STEP_DECIDE) begin
          cell_done = 1'b1;
          removable = nb_sum < neighbour_limit;
        end

        if (cell_done) begin
          step_next     = STEP_CENTER;
          nb_count_next = '0;
          cleared       = removable & peel;
          if (removable) begin
            if (peel) begin
              mem_we             = 1'b1;
              mem_wdata          = 1'b0;
              removed_count_next = sat_inc(removed_count);
            end else begin
              first_count_next = sat_inc(first_count);
            end
          end
          changed           = pass_changed | cleared;
          pass_changed_next = changed;
          // advance to the next cell, closing the pass at the grid end
          if (last_col) begin
            c_next = '0;
            if (last_row) begin
              r_next = '0;
              if (!peel) begin
                peel_next         = 1'b1;
                pass_changed_next = 1'b0;
              end else if (changed) begin
                pass_changed_next = 1'b0;
              end else begin
                state_next = ST_FINISH;
              end
            end else begin
              r_next = r + ROW_W'(1);
            end
          end else begin
            c_next = c + COL_W'(1);
          end
        end else begin
          step_next = step + STEP_W'(1);
        end
      end

      ST_FINISH: begin
        if (!out_valid || results.ready) begin
          out_load   = 1'b1;
          state_next = ST_LOAD;
        end
      end

      default: state_next = ST_LOAD;
    endcase

    // a geometry write restarts the load
    if (geom_write) begin
      r_next = '0;
      c_next = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      r             <= '0;
      c             <= '0;
      step          <= STEP_CENTER;
      peel          <= 1'b0;
      nb_count      <= '0;
      first_count   <= '0;
      removed_count <= '0;
      pass_changed  <= 1'b0;
      rd_ok         <= 1'b0;
    end else begin
      state         <= state_next;
      r             <= r_next;
      c             <= c_next;
      step          <= step_next;
      peel          <= peel_next;
      nb_count      <= nb_count_next;
      first_count   <= first_count_next;
      removed_count <= removed_count_next;
      pass_changed  <= pass_changed_next;
      rd_ok         <= rd_ok_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows       <= GRID_ROWS_RESET;
      grid_cols       <= GRID_COLS_RESET;
      neighbour_limit <= NEIGHBOUR_LIMIT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_GRID_ROWS:       grid_rows       <= cfg.data;
        REG_GRID_COLS:       grid_cols       <= cfg.data;
        REG_NEIGHBOUR_LIMIT: neighbour_limit <= cfg.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // cell store: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) cell_store[mem_waddr] <= mem_wdata;
    rd_data <= cell_store[nb_addr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_single <= first_count;
      out_total  <= removed_count;
    end
  end

  assign cells.ready               = (state == ST_LOAD);
  assign cfg.ready                 = 1'b1;
  assign results.valid             = out_valid;
  assign results.single_pass_count = out_single;
  assign results.total_removed     = out_total;

endmodule

`default_nettype wire

/* design/gncp_checker.sv */
// gncp_checker: port-level checks on the result channel of the block
// depends on gncp_pkg; bound to grid_neighbour_count_peeling below
`default_nettype none

module gncp_checker import gncp_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               res_valid,
  input wire logic               res_ready,
  input wire logic [COUNT_W-1:0] res_single,
  input wire logic [COUNT_W-1:0] res_total
);

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_single) && $stable(res_total))
    else $error("result changed or dropped while stalled");

  // every cell removable at the start is peeled eventually
  a_total_covers_single: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_total >= res_single)
    else $error("total_removed below single_pass_count");

  // the removed count cannot exceed the number of cells in the largest grid
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_total <= COUNT_W'(MAX_CELLS)))
    else $error("total_removed above grid size");

endmodule

bind grid_neighbour_count_peeling gncp_checker u_gncp_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (results.valid),
  .res_ready  (results.ready),
  .res_single (results.single_pass_count),
  .res_total  (results.total_removed)
);

`default_nettype wire

/* verif/grid_neighbour_count_peeling_tb.sv */
`timescale 1ns / 1ps
// grid_neighbour_count_peeling_tb: loads random and directed grids, predicts both
// counts of every full grid in a local model and checks each result item against it
// depends on gncp_pkg, gncp_if and grid_neighbour_count_peeling

module grid_neighbour_count_peeling_tb;
  import gncp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 1500;
  localparam int RANDOM_ITEMS  = 200;
  localparam int RANDOM_GRIDS  = 14;
  localparam int QUIET_ITEMS   = 60;
  localparam int TIMEOUT_NS    = 50_000_000;

  typedef struct packed {
    logic [COUNT_W-1:0] single_pass;
    logic [COUNT_W-1:0] removed;
  } grid_counts_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // tb side of the channels
  logic                  cell_vld = 1'b0;
  logic                  cell_bit = 1'b0;
  logic                  res_rdy  = 1'b0;
  logic                  cfg_vld  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_dat  = '0;

  gncp_cell_if   cell_ch ();
  gncp_result_if res_ch ();
  gncp_cfg_if    cfg_ch ();

  assign cell_ch.valid         = cell_vld;
  assign cell_ch.cell_occupied = cell_bit;
  assign res_ch.ready          = res_rdy;
  assign cfg_ch.valid          = cfg_vld;
  assign cfg_ch.index          = cfg_idx;
  assign cfg_ch.data           = cfg_dat;

  grid_neighbour_count_peeling dut (
    .clk     (clk),
    .rst     (rst),
    .cells   (cell_ch),
    .results (res_ch),
    .cfg     (cfg_ch)
  );

  initial forever #5 clk = ~clk;

  // local copy of the grid store, the load pointer and the registers
  bit                   grid_cells [MAX_CELLS];
  int unsigned          fill_pos  = 0;
  logic [CFG_DIM_W-1:0] cfg_rows  = GRID_ROWS_RESET;
  logic [CFG_DIM_W-1:0] cfg_cols  = GRID_COLS_RESET;
  logic [LIMIT_W-1:0]   cfg_limit = NEIGHBOUR_LIMIT_RESET;

  logic         cell_feed [$];
  grid_counts_t counts_due [$];
  grid_counts_t due_counts;

  int errors        = 0;
  int feed_gap      = 0;
  int stall_left    = 0;
  int hold_left     = 0;
  bit hold_taken    = 1'b0;
  bit long_hold_req = 1'b0;
  bit idle_on       = 1'b1;
  int rand_items    = 0;
  int rand_grids    = 0;

  // zero acts as one, anything past the top as the top
  function automatic int used_extent(logic [CFG_DIM_W-1:0] v, int top);
    if (v == '0) return 1;
    if (int'(v) > top) return top;
    return int'(v);
  endfunction

  function automatic int grid_size();
    return used_extent(cfg_rows, MAX_ROWS) * used_extent(cfg_cols, MAX_COLS);
  endfunction

  // occupied cells among the eight around (r, c), outside counts as empty
  function automatic int live_around(int r, int c, int rows, int cols);
    int n = 0;
    for (int dr = -1; dr <= 1; dr++)
      for (int dc = -1; dc <= 1; dc++)
        if ((dr != 0 || dc != 0) && r + dr >= 0 && c + dc >= 0 &&
            r + dr < rows && c + dc < cols)
          n += grid_cells[(r + dr) * MAX_COLS + c + dc];
    return n;
  endfunction

  function automatic bit peelable(int r, int c, int rows, int cols);
    return grid_cells[r * MAX_COLS + c] && live_around(r, c, rows, cols) < int'(cfg_limit);
  endfunction

  // store one accepted cell; on the last cell count, then peel until stable
  task automatic store_cell(logic occ);
    int rows, cols, total;
    logic [COUNT_W-1:0] first, peeled;
    bit changed;
    grid_counts_t due;
    rows  = used_extent(cfg_rows, MAX_ROWS);
    cols  = used_extent(cfg_cols, MAX_COLS);
    total = rows * cols;
    if (fill_pos >= total) fill_pos = 0;
    grid_cells[(fill_pos / cols) * MAX_COLS + fill_pos % cols] = occ;
    fill_pos++;
    if (fill_pos < total) return;
    first = '0;
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < cols; c++)
        if (peelable(r, c, rows, cols) && first != '1) first++;
    // in-place passes, later tests see earlier clears of the same pass
    peeled = '0;
    do begin
      changed = 1'b0;
      for (int r = 0; r < rows; r++)
        for (int c = 0; c < cols; c++)
          if (peelable(r, c, rows, cols)) begin
            grid_cells[r * MAX_COLS + c] = 1'b0;
            if (peeled != '1) peeled++;
            changed = 1'b1;
          end
    end while (changed);
    due.single_pass = first;
    due.removed     = peeled;
    counts_due = {counts_due, due};
    fill_pos = 0;
  endtask

  // cell driver, fed from cell_feed
  always @(posedge clk) begin
    if (rst) begin
      cell_vld <= 1'b0;
      feed_gap = 0;
    end else begin
      if (cell_vld && cell_ch.ready) store_cell(cell_bit);
      if (!cell_vld || cell_ch.ready) begin
        if (feed_gap > 0) begin
          feed_gap--;
          cell_vld <= 1'b0;
        end else if (cell_feed.size() == 0) begin
          cell_vld <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
          feed_gap = $urandom_range(0, 11);
          cell_vld <= 1'b0;
        end else begin
          cell_vld <= 1'b1;
          cell_bit <= cell_feed.pop_front();
        end
      end
    end
  end

  // result monitor and ready pattern, with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      res_rdy <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (res_ch.valid && res_rdy) begin
        if (counts_due.size() == 0) begin
          $error("result item with no grid loaded: single_pass_count=%0d total_removed=%0d",
                 res_ch.single_pass_count, res_ch.total_removed);
          errors++;
        end else begin
          due_counts = counts_due.pop_front();
          if (res_ch.single_pass_count !== due_counts.single_pass) begin
            $error("single_pass_count: expected %0d, got %0d",
                   due_counts.single_pass, res_ch.single_pass_count);
            errors++;
          end
          if (res_ch.total_removed !== due_counts.removed) begin
            $error("total_removed: expected %0d, got %0d",
                   due_counts.removed, res_ch.total_removed);
            errors++;
          end
        end
      end
      if (long_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_rdy <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_rdy <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 11);
        res_rdy <= 1'b0;
      end else begin
        res_rdy <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_vld <= 1'b1;
    cfg_idx <= idx;
    cfg_dat <= val;
    do begin
      @(posedge clk);
    end while (!cfg_ch.ready);
    cfg_vld <= 1'b0;
    // geometry writes restart the load
    case (idx)
      REG_GRID_ROWS: begin
        cfg_rows = val;
        fill_pos = 0;
      end
      REG_GRID_COLS: begin
        cfg_cols = val;
        fill_pos = 0;
      end
      REG_NEIGHBOUR_LIMIT: cfg_limit = val[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  // sender holds until every queued cell went in and every count came back
  task automatic wait_results();
    while (cell_feed.size() != 0 || cell_vld || counts_due.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_geometry(logic [CFG_DATA_W-1:0] rows, logic [CFG_DATA_W-1:0] cols,
                              logic [CFG_DATA_W-1:0] lim, bit with_limit);
    settle();
    write_reg(REG_GRID_ROWS, rows);
    write_reg(REG_GRID_COLS, cols);
    if (with_limit) write_reg(REG_NEIGHBOUR_LIMIT, lim);
  endtask

  // n cells, each occupied with chance fill/8
  task automatic push_cells(int n, int fill);
    repeat (n) cell_feed = {cell_feed, logic'($urandom_range(0, 7) < fill)};
    rand_items += n;
  endtask

  function automatic logic [CFG_DATA_W-1:0] limit_word(int lim);
    logic [CFG_DATA_W-1:0] w;
    w = CFG_DATA_W'($urandom);
    w[LIMIT_W-1:0] = LIMIT_W'(lim);
    return w;
  endfunction

  initial begin
    int rows, cols, n;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: every cell is a whole grid
    cell_feed = {cell_feed, 1'b1};
    cell_feed = {cell_feed, 1'b0};
    // limit zero, upper data bits set and ignored
    settle();
    write_reg(REG_NEIGHBOUR_LIMIT, 9'h1F0);
    cell_feed = {cell_feed, 1'b1};
    // zero geometry acts as one cell, limit above eight peels everything
    set_geometry('0, '0, '1, 1'b1);
    cell_feed = {cell_feed, 1'b1};
    // full 3x3 block under the default limit
    set_geometry(9'd3, 9'd3, 9'd4, 1'b1);
    repeat (9) cell_feed = {cell_feed, 1'b1};
    // geometry rewritten mid-load restarts the grid
    set_geometry(9'd2, 9'd2, 9'd4, 1'b0);
    cell_feed = {cell_feed, 1'b1};
    cell_feed = {cell_feed, 1'b1};
    settle();
    write_reg(REG_GRID_COLS, 9'd2);
    cell_feed = {cell_feed, 1'b1};
    cell_feed = {cell_feed, 1'b0};
    cell_feed = {cell_feed, 1'b1};
    cell_feed = {cell_feed, 1'b1};
    // unused register index, then an empty grid
    settle();
    write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    repeat (4) cell_feed = {cell_feed, 1'b0};

    // receiver holds off while small grids keep coming, so the input stalls
    set_geometry(9'd2, 9'd2, limit_word(4), 1'b1);
    @(negedge clk);
    long_hold_req = 1'b1;
    repeat (6) push_cells(grid_size(), $urandom_range(5, 8));

    // longest line: an oversized dimension clamps to the top, the other is 0 or 1
    if ($urandom_range(0, 1) == 0)
      set_geometry(9'd511, CFG_DATA_W'($urandom_range(0, 1)),
                   limit_word($urandom_range(0, 15)), 1'b1);
    else
      set_geometry(CFG_DATA_W'($urandom_range(0, 1)), 9'd511,
                   limit_word($urandom_range(0, 15)), 1'b1);
    push_cells(grid_size(), $urandom_range(4, 8));

    // random small grids, mostly dense so peeling runs several passes
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS || rand_grids < RANDOM_GRIDS) begin
      if (rand_items >= RANDOM_ITEMS - QUIET_ITEMS) idle_on = 1'b0;
      rows = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 6);
      cols = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 6);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(2, 6);
      set_geometry(CFG_DATA_W'(rows), CFG_DATA_W'(cols), limit_word(n),
                   $urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 5) == 0) wait_results();
        push_cells(grid_size(),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom_range(5, 8));
        rand_grids++;
      end
      // sometimes leave a grid half loaded for the next geometry write to drop
      if ($urandom_range(0, 4) == 0 && grid_size() > 1)
        push_cells($urandom_range(1, grid_size() - 1), $urandom_range(0, 8));
    end

    settle();
    if (errors == 0)
      $display("grid_neighbour_count_peeling_tb passed");
    else
      $display("grid_neighbour_count_peeling_tb failed");
    $finish;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("grid_neighbour_count_peeling_tb failed");
    $finish;
  end

endmodule
